### src/lruc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lruc_pkg
// Shared constants and types for the lru key-value cache: defaults, request
// codes, the scan record that travels down the cell chain and the update
// command broadcast to all cells.
// ----------------------------------------------------------------------------
package lruc_pkg;

    localparam int ENTRIES_DEF     = 8;
    localparam int KEY_WIDTH_DEF   = 64;
    localparam int VALUE_WIDTH_DEF = 64;

    // field widths sized for the largest entry count the design supports (64)
    localparam int IDX_MAX_W  = 6;
    localparam int RANK_MAX_W = 6;
    localparam int LIM_W      = 7;

    localparam int          CAP_W     = 4;
    localparam logic [CAP_W-1:0] CAP_RESET = 4'd5;

    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_STORE  = 1'b1;

    typedef struct packed {
        logic                  found;
        logic [IDX_MAX_W-1:0]  found_idx;
        logic [RANK_MAX_W-1:0] found_rank;
        logic                  any_valid;
        logic [RANK_MAX_W-1:0] max_rank;
        logic [IDX_MAX_W-1:0]  max_idx;
        logic                  free_found;
        logic [IDX_MAX_W-1:0]  free_idx;
    } scan_rec_t;

    typedef struct packed {
        logic                 valid;
        logic [IDX_MAX_W-1:0] slot;
        logic [LIM_W-1:0]     limit;
        logic                 write_key;
        logic                 write_value;
        logic                 set_valid;
    } cmd_t;

endpackage : lruc_pkg
`default_nettype wire

### src/lruc_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lruc_cell
// One cache entry: key, value, valid bit and recency rank. Folds its entry
// into the scan record passing by and applies broadcast update commands.
// ----------------------------------------------------------------------------
module lruc_cell
    import lruc_pkg::*;
#(
    parameter int ENTRIES     = ENTRIES_DEF,
    parameter int INDEX       = 0,
    parameter int KEY_WIDTH   = KEY_WIDTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic [KEY_WIDTH-1:0]   req_key,
    input  wire logic [VALUE_WIDTH-1:0] req_value,
    input  wire cmd_t                   cmd,
    input  wire logic                   scan_in_vld,
    input  wire scan_rec_t              scan_in,
    input  wire logic [VALUE_WIDTH-1:0] scan_in_value,
    output logic                        scan_out_vld,
    output scan_rec_t                   scan_out,
    output logic [VALUE_WIDTH-1:0]      scan_out_value
);

    localparam int RW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic                   valid_reg;
    logic [RW-1:0]          rank_reg;
    logic [KEY_WIDTH-1:0]   key_reg;
    logic [VALUE_WIDTH-1:0] value_reg;

    logic                   scan_vld_reg;
    scan_rec_t              scan_rec_reg;
    logic [VALUE_WIDTH-1:0] scan_value_reg;

    scan_rec_t              scan_rec_next;
    logic [VALUE_WIDTH-1:0] scan_value_next;

    logic                   match;
    logic                   is_slot;
    logic [RANK_MAX_W-1:0]  rank_ext;

    assign match    = valid_reg && (key_reg == req_key);
    assign is_slot  = (cmd.slot == IDX_MAX_W'(INDEX));
    assign rank_ext = RANK_MAX_W'(rank_reg);

    always_comb
    begin
        scan_rec_next   = scan_in;
        scan_value_next = scan_in_value;
        if (match && !scan_in.found)
        begin
            scan_rec_next.found      = 1'b1;
            scan_rec_next.found_idx  = IDX_MAX_W'(INDEX);
            scan_rec_next.found_rank = rank_ext;
            scan_value_next          = value_reg;
        end
        if (valid_reg && (!scan_in.any_valid || (rank_ext > scan_in.max_rank)))
        begin
            scan_rec_next.any_valid = 1'b1;
            scan_rec_next.max_rank  = rank_ext;
            scan_rec_next.max_idx   = IDX_MAX_W'(INDEX);
        end
        if (!valid_reg && !scan_in.free_found)
        begin
            scan_rec_next.free_found = 1'b1;
            scan_rec_next.free_idx   = IDX_MAX_W'(INDEX);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            rank_reg     <= '0;
            scan_vld_reg <= 1'b0;
        end
        else
        begin
            scan_vld_reg <= scan_in_vld;
            if (cmd.valid)
            begin
                if (is_slot)
                begin
                    rank_reg <= '0;
                    if (cmd.set_valid)
                    begin
                        valid_reg <= 1'b1;
                    end
                end
                else if (valid_reg && (LIM_W'(rank_reg) < cmd.limit))
                begin
                    rank_reg <= RW'(rank_reg + 1'b1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        scan_rec_reg   <= scan_rec_next;
        scan_value_reg <= scan_value_next;
        if (cmd.valid && is_slot)
        begin
            if (cmd.write_key)
            begin
                key_reg <= req_key;
            end
            if (cmd.write_value)
            begin
                value_reg <= req_value;
            end
        end
    end

    assign scan_out_vld   = scan_vld_reg;
    assign scan_out       = scan_rec_reg;
    assign scan_out_value = scan_value_reg;

endmodule : lruc_cell
`default_nettype wire

### src/lruc_chain.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lruc_chain
// Row of entry cells. A scan record enters cell 0 and moves one cell per
// cycle; update commands reach every cell at once.
// ----------------------------------------------------------------------------
module lruc_chain
    import lruc_pkg::*;
#(
    parameter int ENTRIES     = ENTRIES_DEF,
    parameter int KEY_WIDTH   = KEY_WIDTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic [KEY_WIDTH-1:0]   req_key,
    input  wire logic [VALUE_WIDTH-1:0] req_value,
    input  wire logic                   launch,
    input  wire cmd_t                   cmd,
    output logic                        result_vld,
    output scan_rec_t                   result,
    output logic [VALUE_WIDTH-1:0]      result_value
);

    logic                   vld_link   [ENTRIES+1];
    scan_rec_t              rec_link   [ENTRIES+1];
    logic [VALUE_WIDTH-1:0] value_link [ENTRIES+1];

    assign vld_link[0]   = launch;
    assign rec_link[0]   = '0;
    assign value_link[0] = '0;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        lruc_cell #(
            .ENTRIES     (ENTRIES),
            .INDEX       (i),
            .KEY_WIDTH   (KEY_WIDTH),
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .req_key        (req_key),
            .req_value      (req_value),
            .cmd            (cmd),
            .scan_in_vld    (vld_link[i]),
            .scan_in        (rec_link[i]),
            .scan_in_value  (value_link[i]),
            .scan_out_vld   (vld_link[i+1]),
            .scan_out       (rec_link[i+1]),
            .scan_out_value (value_link[i+1])
        );
    end

    assign result_vld   = vld_link[ENTRIES];
    assign result       = rec_link[ENTRIES];
    assign result_value = value_link[ENTRIES];

endmodule : lruc_chain
`default_nettype wire

### src/lru_key_value_cache_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lru_key_value_cache_core
// Fully associative key-value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Each request is a lookup or a store and gives one result beat. From
// acceptance, the request is registered, the scan record walks the row of
// entry cells (one cell per cycle), the scan record is latched, and, once
// the output register is free, the update is applied to all cells and the
// output register loaded. A new request is accepted once the previous one
// has loaded its result, even while that result still waits on out_ready,
// so the cache takes no new request while one is still in flight.
// capacity may be written at any time the cache is idle; zero acts as one and
// values above ENTRIES act as ENTRIES. No clearing pass is needed after reset.
module lru_key_value_cache_core
    import lruc_pkg::*;
#(
    parameter int ENTRIES     = ENTRIES_DEF,
    parameter int KEY_WIDTH   = KEY_WIDTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic                   req_type,
    input  wire logic [KEY_WIDTH-1:0]   key,
    input  wire logic [VALUE_WIDTH-1:0] value,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic                        hit,
    output logic [VALUE_WIDTH-1:0]      read_value,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CAP_W-1:0]       cfg_data
);

    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_SCAN    = 2'd1;
    localparam logic [1:0] ST_RESOLVE = 2'd2;

    logic [1:0]             state_reg, state_next;
    logic [CAP_W-1:0]       cap_reg;
    logic [CNT_W-1:0]       count_reg;
    logic                   launch_reg;
    logic                   req_type_reg;
    logic [KEY_WIDTH-1:0]   req_key_reg;
    logic [VALUE_WIDTH-1:0] req_value_reg;
    scan_rec_t              res_reg;
    logic [VALUE_WIDTH-1:0] res_value_reg;
    logic                   out_valid_reg;
    logic                   hit_reg;
    logic [VALUE_WIDTH-1:0] read_value_reg;

    logic                   in_accept;
    logic                   chain_vld;
    scan_rec_t              chain_rec;
    logic [VALUE_WIDTH-1:0] chain_value;
    logic                   do_resolve;
    logic [CMP_W-1:0]       cap_ext;
    logic [CMP_W-1:0]       eff_cap;
    logic                   evict;
    cmd_t                   cmd;

    assign in_ready   = (state_reg == ST_IDLE);
    assign in_accept  = in_valid && in_ready;
    assign cfg_ready  = 1'b1;
    assign do_resolve = (state_reg == ST_RESOLVE) && (!out_valid_reg || out_ready);

    // capacity clamped to 1..ENTRIES
    always_comb
    begin
        cap_ext = CMP_W'(cap_reg);
        if (cap_ext == '0)
        begin
            eff_cap = CMP_W'(1);
        end
        else if (cap_ext > CMP_W'(ENTRIES))
        begin
            eff_cap = CMP_W'(ENTRIES);
        end
        else
        begin
            eff_cap = cap_ext;
        end
    end

    assign evict = !res_reg.found && (req_type_reg == REQ_STORE)
                   && (CMP_W'(count_reg) >= eff_cap);

    always_comb
    begin
        cmd             = '0;
        cmd.valid       = do_resolve && (res_reg.found || (req_type_reg == REQ_STORE));
        if (res_reg.found)
        begin
            cmd.slot        = res_reg.found_idx;
            cmd.limit       = LIM_W'(res_reg.found_rank);
            cmd.write_value = (req_type_reg == REQ_STORE);
        end
        else if (evict)
        begin
            cmd.slot        = res_reg.max_idx;
            cmd.limit       = LIM_W'(res_reg.max_rank);
            cmd.write_key   = 1'b1;
            cmd.write_value = 1'b1;
        end
        else
        begin
            cmd.slot        = res_reg.free_idx;
            cmd.limit       = LIM_W'(ENTRIES);
            cmd.write_key   = 1'b1;
            cmd.write_value = 1'b1;
            cmd.set_valid   = 1'b1;
        end
    end

    lruc_chain #(
        .ENTRIES     (ENTRIES),
        .KEY_WIDTH   (KEY_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_chain (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_key      (req_key_reg),
        .req_value    (req_value_reg),
        .launch       (launch_reg),
        .cmd          (cmd),
        .result_vld   (chain_vld),
        .result       (chain_rec),
        .result_value (chain_value)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (chain_vld)
                begin
                    state_next = ST_RESOLVE;
                end
            end
            ST_RESOLVE:
            begin
                if (do_resolve)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cap_reg       <= CAP_RESET;
            count_reg     <= '0;
            launch_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            launch_reg <= in_accept;
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
            if (cmd.valid && cmd.set_valid)
            begin
                count_reg <= CNT_W'(count_reg + 1'b1);
            end
            if (do_resolve)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            req_type_reg  <= req_type;
            req_key_reg   <= key;
            req_value_reg <= value;
        end
        if (chain_vld)
        begin
            res_reg       <= chain_rec;
            res_value_reg <= chain_value;
        end
        if (do_resolve)
        begin
            hit_reg        <= res_reg.found;
            read_value_reg <= (res_reg.found && (req_type_reg == REQ_LOOKUP))
                              ? res_value_reg : '0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign hit        = hit_reg;
    assign read_value = read_value_reg;

`ifndef SYNTH
    // the fill count never passes the number of cells
    assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(count_reg) <= CMP_W'(ENTRIES))
        else $error("entry count above entry total");

    // a scan record only comes out of the chain while a scan is running
    assert property (@(posedge clk) disable iff (!rst_n)
        chain_vld |-> (state_reg == ST_SCAN))
        else $error("scan result outside scan state");

    // an insert into a free slot needs the scan to have found one
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.set_valid) |-> res_reg.free_found)
        else $error("insert without a free slot");

    // an eviction needs at least one valid entry
    assert property (@(posedge clk) disable iff (!rst_n)
        (do_resolve && evict) |-> res_reg.any_valid)
        else $error("eviction with no valid entry");

    // a new result beat is only loaded by the resolve step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_RESOLVE))
        else $error("result beat without resolve");
`endif

endmodule : lru_key_value_cache_core
`default_nettype wire

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the lru key-value cache core. A short table of
// lookups, stores and capacity writes runs first, followed by randomized
// phases over a small key pool with random stalls on both sides in most phases.
// Every result beat is compared in order against the table's expected result or a behavioral model of the cache.
// ----------------------------------------------------------------------------
module tb
    import lruc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES = ENTRIES_DEF;
    localparam int KW      = KEY_WIDTH_DEF;
    localparam int VW      = VALUE_WIDTH_DEF;
    localparam int LATENCY = ENTRIES + 2;
    localparam int PHASES  = 16;
    localparam int PHASE_ITEMS = 116;

    localparam logic [63:0] ONES = '1;
    localparam logic [63:0] MSB  = 64'h8000_0000_0000_0000;

    typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

    typedef struct packed {
        logic          hit;
        logic [VW-1:0] data;
    } cache_result_t;

    typedef struct packed {
        row_kind_t         kind;
        logic [CAP_W-1:0]  cap;
        logic              rt;
        logic [KW-1:0]     k;
        logic [VW-1:0]     v;
        logic              typed;
        cache_result_t     want;
    } stim_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic                 req_type = REQ_LOOKUP;
    logic [KW-1:0]        key = '0;
    logic [VW-1:0]        value = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 hit;
    logic [VW-1:0]        read_value;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CAP_W-1:0]     cfg_data = '0;

    // model of the cache contents
    logic [KW-1:0]        line_key [ENTRIES];
    logic [VW-1:0]        line_val [ENTRIES];
    bit                   line_used [ENTRIES];
    int unsigned          line_age [ENTRIES];
    int unsigned          lines_in_use;
    logic [CAP_W-1:0]     capacity_reg;

    cache_result_t        pending_results[$];
    stim_row_t            directed_rows[$];
    logic [KW-1:0]        key_pool[12];

    int mismatches   = 0;
    int reqs_sent    = 0;
    int beats_seen   = 0;
    int hits_seen    = 0;
    int evictions    = 0;
    int cap_writes   = 0;
    int ready_hold   = 0;
    int ready_odds   = 6;
    bit quiet        = 1'b0;

    lru_key_value_cache_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .key        (key),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hit        (hit),
        .read_value (read_value),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        $display("mismatch %0d at %0t ns: %s got %h expected %h",
                 mismatches, $time, what, got, want);
    endtask

    // line s becomes most recent; younger valid lines than limit age by one
    function automatic void make_recent(input int s, input int unsigned limit);
        for (int i = 0; i < ENTRIES; i++)
            if (i != s && line_used[i] && line_age[i] < limit)
                line_age[i]++;
        line_age[s] = 0;
    endfunction

    function automatic cache_result_t cache_access(input logic rt, input logic [KW-1:0] k,
                                                   input logic [VW-1:0] v);
        cache_result_t r;
        int            found;
        int            slot;
        int unsigned   oldest;
        int unsigned   cap_eff;
        r = '0;
        found = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (found < 0 && line_used[i] && line_key[i] == k)
                found = i;
        if (found >= 0) begin
            r.hit = 1'b1;
            hits_seen++;
            if (rt == REQ_LOOKUP)
                r.data = line_val[found];
            else
                line_val[found] = v;
            make_recent(found, line_age[found]);
            return r;
        end
        if (rt == REQ_LOOKUP)
            return r;
        cap_eff = capacity_reg;
        if (cap_eff < 1)
            cap_eff = 1;
        if (cap_eff > ENTRIES)
            cap_eff = ENTRIES;
        if (lines_in_use >= cap_eff) begin
            slot = -1;
            oldest = 0;
            for (int i = 0; i < ENTRIES; i++)
                if (line_used[i] && (slot < 0 || line_age[i] > oldest)) begin
                    slot = i;
                    oldest = line_age[i];
                end
            evictions++;
            line_key[slot] = k;
            line_val[slot] = v;
            make_recent(slot, oldest);
        end else begin
            slot = -1;
            for (int i = 0; i < ENTRIES; i++)
                if (slot < 0 && !line_used[i])
                    slot = i;
            line_key[slot] = k;
            line_val[slot] = v;
            line_used[slot] = 1'b1;
            lines_in_use++;
            make_recent(slot, ENTRIES);
        end
        return r;
    endfunction

    function automatic stim_row_t mk_req(input logic rt, input logic [63:0] k,
                                         input logic [63:0] v, input logic typed,
                                         input logic h, input logic [63:0] d);
        stim_row_t row;
        row.kind = ROW_REQ;
        row.cap = '0;
        row.rt = rt;
        row.k = k;
        row.v = v;
        row.typed = typed;
        row.want.hit = h;
        row.want.data = d;
        return row;
    endfunction

    function automatic stim_row_t mk_cfg(input logic [CAP_W-1:0] c);
        stim_row_t row;
        row = '0;
        row.kind = ROW_CFG;
        row.cap = c;
        return row;
    endfunction

    function automatic logic [63:0] rand_word();
        int pick;
        pick = $urandom_range(0, 15);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return ONES;
        return {$urandom, $urandom};
    endfunction

    // in_valid is left high after a beat; anything that is not a new beat lowers it
    task automatic send_req(input logic rt, input logic [KW-1:0] k, input logic [VW-1:0] v,
                            input logic typed, input cache_result_t want);
        cache_result_t pred;
        @(negedge clk);
        in_valid <= 1'b1;
        req_type <= rt;
        key <= k;
        value <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pred = cache_access(rt, k, v);
        pending_results.push_back(typed ? want : pred);
        reqs_sent++;
    endtask

    task automatic pause_sender(input int n);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] c);
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= c;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        capacity_reg = c;
        cap_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // result side: random stall bursts on out_ready
    always @(negedge clk) begin
        if (ready_hold > 0) begin
            out_ready <= 1'b0;
            ready_hold <= ready_hold - 1;
        end else if (!quiet && ready_odds > 0 && $urandom_range(1, ready_odds) == 1) begin
            out_ready <= 1'b0;
            ready_hold <= $urandom_range(0, 4);
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin : check_beat
        cache_result_t want;
        if (rst_n && out_valid && out_ready) begin
            beats_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("result beat with nothing pending, read_value", read_value, '0);
            end else begin
                want = pending_results.pop_front();
                if (hit !== want.hit)
                    report_mismatch("hit", hit, want.hit);
                if (read_value !== want.data)
                    report_mismatch("read_value", read_value, want.data);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("timeout at %0t ns", $time);
        $display("simulation failed");
        $finish;
    end

    initial begin
        int idle_odds;
        int pool_n;
        int pick;
        logic [KW-1:0] k;
        for (int i = 0; i < ENTRIES; i++) begin
            line_key[i] = '0;
            line_val[i] = '0;
            line_used[i] = 1'b0;
            line_age[i] = 0;
        end
        lines_in_use = 0;
        capacity_reg = CAP_RESET;

        // capacity is 5 out of reset
        directed_rows.push_back(mk_req(REQ_LOOKUP, '0, '0, 1, 0, '0));
        directed_rows.push_back(mk_req(REQ_STORE, '0, ONES, 1, 0, '0));
        directed_rows.push_back(mk_req(REQ_STORE, ONES, '0, 1, 0, '0));
        directed_rows.push_back(mk_req(REQ_LOOKUP, '0, '0, 1, 1, ONES));
        directed_rows.push_back(mk_req(REQ_LOOKUP, ONES, ONES, 1, 1, '0));
        directed_rows.push_back(mk_req(REQ_STORE, '0, 64'h5555_5555_5555_5555, 1, 1, '0));
        directed_rows.push_back(mk_req(REQ_LOOKUP, '0, ONES, 1, 1, 64'h5555_5555_5555_5555));
        directed_rows.push_back(mk_req(REQ_STORE, 64'd1, 64'h0123_4567_89ab_cdef, 1, 0, '0));
        directed_rows.push_back(mk_req(REQ_STORE, 64'd2, 64'hfedc_ba98_7654_3210, 1, 0, '0));
        directed_rows.push_back(mk_req(REQ_STORE, 64'd3, 64'd1, 1, 0, '0));
        directed_rows.push_back(mk_req(REQ_LOOKUP, ONES, '0, 1, 1, '0));
        // full at five: key 0 is the oldest and goes out
        directed_rows.push_back(mk_req(REQ_STORE, 64'd4, MSB, 1, 0, '0));
        directed_rows.push_back(mk_req(REQ_LOOKUP, '0, '0, 1, 0, '0));
        directed_rows.push_back(mk_req(REQ_LOOKUP, 64'd1, '0, 0, 0, '0));
        directed_rows.push_back(mk_req(REQ_STORE, MSB, 64'haaaa_aaaa_aaaa_aaaa, 1, 0, '0));
        directed_rows.push_back(mk_req(REQ_LOOKUP, 64'd2, '0, 1, 0, '0));
        directed_rows.push_back(mk_req(REQ_LOOKUP, MSB, '0, 1, 1, 64'haaaa_aaaa_aaaa_aaaa));
        // zero capacity acts as one, and is below the five lines held
        directed_rows.push_back(mk_cfg(4'd0));
        directed_rows.push_back(mk_req(REQ_STORE, 64'h10, 64'h10, 1, 0, '0));
        directed_rows.push_back(mk_req(REQ_LOOKUP, 64'h10, '0, 1, 1, 64'h10));
        directed_rows.push_back(mk_req(REQ_LOOKUP, 64'd4, '0, 0, 0, '0));
        // above the number of lines saturates
        directed_rows.push_back(mk_cfg(4'd15));
        directed_rows.push_back(mk_req(REQ_STORE, 64'h20, 64'h1234, 1, 0, '0));
        directed_rows.push_back(mk_req(REQ_STORE, 64'h21, ONES, 1, 0, '0));
        directed_rows.push_back(mk_req(REQ_STORE, 64'h22, '0, 1, 0, '0));
        directed_rows.push_back(mk_req(REQ_STORE, 64'h23, 64'h5678, 1, 0, '0));
        directed_rows.push_back(mk_req(REQ_LOOKUP, 64'd3, '0, 0, 0, '0));

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG)
                write_capacity(directed_rows[i].cap);
            else
                send_req(directed_rows[i].rt, directed_rows[i].k, directed_rows[i].v,
                         directed_rows[i].typed, directed_rows[i].want);
        end

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: write_capacity(4'd8);
                1: write_capacity(4'd2);
                2: write_capacity(4'd15);
                3: write_capacity(4'd0);
                4: write_capacity(4'd1);
                5: write_capacity(4'd9);
                6: write_capacity(4'd3);
                7: write_capacity(4'd8);
                default: write_capacity(CAP_W'($urandom_range(0, 15)));
            endcase
            quiet = (p >= PHASES - 2);
            idle_odds = (p % 4 == 1) ? 0 : ((p % 2 == 0) ? 4 : 8);
            ready_odds = (p % 4 == 1) ? 0 : ((p % 2 == 0) ? 4 : 8);
            pool_n = $urandom_range(2, 12);
            foreach (key_pool[j])
                key_pool[j] = rand_word();
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (!quiet && idle_odds > 0 && $urandom_range(1, idle_odds) == 1)
                    pause_sender($urandom_range(1, 5));
                pick = $urandom_range(0, 99);
                k = (pick < 90) ? key_pool[$urandom_range(0, pool_n - 1)] : rand_word();
                if (pick < 45 || (pick >= 90 && pick < 95))
                    send_req(REQ_LOOKUP, k, rand_word(), 0, '0);
                else
                    send_req(REQ_STORE, k, rand_word(), 0, '0);
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);

        $display("covered %0d requests over %0d capacity writes: %0d hits, %0d evictions",
                 reqs_sent, cap_writes, hits_seen, evictions);
        $display("%0d result beats checked, %0d mismatches", beats_seen, mismatches);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule : tb

### sim.f
src/lruc_pkg.sv
src/lruc_cell.sv
src/lruc_chain.sv
src/lru_key_value_cache_core.sv
verif/tb.sv
